FILE: hdl/cshl_pkg.sv
// Package: mode and kind codes, character constants and keyword table for the C lexer.
package cshl_pkg;

	localparam logic [3:0] M_IDLE   = 4'd0;
	localparam logic [3:0] M_SLASH  = 4'd1;
	localparam logic [3:0] M_DOT    = 4'd2;
	localparam logic [3:0] M_LINE   = 4'd3;
	localparam logic [3:0] M_BLOCK  = 4'd4;
	localparam logic [3:0] M_STRING = 4'd5;
	localparam logic [3:0] M_NUMBER = 4'd6;
	localparam logic [3:0] M_IDENT  = 4'd7;
	localparam logic [3:0] M_WAIT   = 4'd8;
	localparam logic [3:0] M_DSPACE = 4'd9;
	localparam logic [3:0] M_DWORD  = 4'd10;

	localparam int F_ZERO   = 0;
	localparam int F_HEX    = 1;
	localparam int F_STAR   = 2;
	localparam int F_ESC    = 3;
	localparam int F_SQUOTE = 4;

	localparam logic [2:0] K_COMMENT   = 3'd0;
	localparam logic [2:0] K_STRING    = 3'd1;
	localparam logic [2:0] K_NUMBER    = 3'd2;
	localparam logic [2:0] K_KEYWORD   = 3'd3;
	localparam logic [2:0] K_FUNCTION  = 3'd4;
	localparam logic [2:0] K_DIRECTIVE = 3'd5;

	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_LF     = 16'h000A;
	localparam logic [15:0] CH_CR     = 16'h000D;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_DQUOTE = 16'h0022;
	localparam logic [15:0] CH_HASH   = 16'h0023;
	localparam logic [15:0] CH_SQUOTE = 16'h0027;
	localparam logic [15:0] CH_LPAREN = 16'h0028;
	localparam logic [15:0] CH_STAR   = 16'h002A;
	localparam logic [15:0] CH_PLUS   = 16'h002B;
	localparam logic [15:0] CH_MINUS  = 16'h002D;
	localparam logic [15:0] CH_DOT    = 16'h002E;
	localparam logic [15:0] CH_SLASH  = 16'h002F;
	localparam logic [15:0] CH_ZERO   = 16'h0030;
	localparam logic [15:0] CH_NINE   = 16'h0039;
	localparam logic [15:0] CH_UP_A   = 16'h0041;
	localparam logic [15:0] CH_UP_E   = 16'h0045;
	localparam logic [15:0] CH_UP_P   = 16'h0050;
	localparam logic [15:0] CH_UP_X   = 16'h0058;
	localparam logic [15:0] CH_UP_Z   = 16'h005A;
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_USCORE = 16'h005F;
	localparam logic [15:0] CH_LO_A   = 16'h0061;
	localparam logic [15:0] CH_LO_E   = 16'h0065;
	localparam logic [15:0] CH_LO_P   = 16'h0070;
	localparam logic [15:0] CH_LO_X   = 16'h0078;
	localparam logic [15:0] CH_LO_Z   = 16'h007A;

	localparam int NUM_KW = 56;
	localparam logic [3:0] LEN_MAX = 4'd15;

	function automatic logic [119:0] kw_word(input int k);
		case (k)
			0: return "alignas";        1: return "alignof";
			2: return "auto";           3: return "bool";
			4: return "break";          5: return "case";
			6: return "char";           7: return "const";
			8: return "constexpr";      9: return "continue";
			10: return "default";       11: return "do";
			12: return "double";        13: return "else";
			14: return "enum";          15: return "extern";
			16: return "false";         17: return "float";
			18: return "for";           19: return "goto";
			20: return "if";            21: return "inline";
			22: return "int";           23: return "long";
			24: return "nullptr";       25: return "register";
			26: return "restrict";      27: return "return";
			28: return "short";         29: return "signed";
			30: return "sizeof";        31: return "static";
			32: return 120'({"static", "_assert"});
			33: return "struct";
			34: return "switch";
			35: return 120'({"thread", "_local"});
			36: return "true";          37: return "typedef";
			38: return "typeof";
			39: return 120'({"typeof", "_unqual"});
			40: return "union";         41: return "unsigned";
			42: return "void";          43: return "volatile";
			44: return "while";         45: return "_Alignas";
			46: return "_Alignof";      47: return "_Atomic";
			48: return "_BitInt";       49: return "_Bool";
			50: return "_Complex";      51: return "_Generic";
			52: return "_Imaginary";    53: return "_Noreturn";
			54: return 120'({"_Static", "_assert"});
			default: return 120'({"_Thread", "_local"});
		endcase
	endfunction

	function automatic logic [7:0] kw_at(input int k, input logic [3:0] i);
		logic [119:0] w;
		int n;
		w = kw_word(k);
		n = 0;
		for (int j = 0; j < 15; j++) begin
			if (w[8*j +: 8] != 8'd0) n++;
		end
		if (int'(i) < n) return w[8*(n-1-int'(i)) +: 8];
		return 8'd0;
	endfunction

	function automatic logic [55:0] ident_add(input logic [55:0] cand, input logic [3:0] len,
		input logic [15:0] c);
		logic [55:0] r;
		logic [7:0] ch;
		r = cand;
		for (int k = 0; k < NUM_KW; k++) begin
			ch = kw_at(k, len);
			if (len == LEN_MAX || ch == 8'd0 || {8'd0, ch} != c) r[k] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic is_kw(input logic [55:0] cand, input logic [3:0] len);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (cand[k] && kw_at(k, len) == 8'd0) hit = 1'b1;
		end
		return hit && (len != LEN_MAX);
	endfunction

endpackage

FILE: hdl/c_syntax_highlight_lexer_core.sv
// Top level: streaming C lexer that turns characters into highlight spans.
// Takes one character beat per cycle and answers each with zero, one or two span beats through
// an input register, then scan logic into an eight-entry result queue. Input is
// accepted while at most four results are queued, so the rate is one character per cycle
// unless the downstream side stalls. A beat with tlast ends the source text: open tokens are
// closed at its end, the last result carries tlast, and if that final beat yields no span a marker beat
// with the present flag clear is sent. Positions saturate at 2^POSITION_WIDTH-1.
module c_syntax_highlight_lexer_core #(
	parameter int POSITION_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // code_unit
	input  logic        s_axis_tlast,   // final_char
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// span_start, span_end, zero fill
	output logic [((2*POSITION_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser,   // span_kind[2:0], span_present
	output logic        m_axis_tlast    // source_done
);
	import cshl_pkg::*;

	localparam int P = POSITION_WIDTH;
	localparam int TDW = ((2*P+7)/8)*8;
	localparam int DEPTH = 8;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};

	typedef struct packed {
		logic [P-1:0] s;
		logic [P-1:0] e;
		logic [2:0]   k;
		logic         pr;
		logic         dn;
	} res_t;

	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        last_s1;

	logic [3:0]   mode_q;
	logic [P-1:0] pos_q, beg_q, fin_q;
	logic [55:0]  cand_q;
	logic [3:0]   len_q;
	logic [15:0]  prev_q;
	logic [4:0]   flags_q;

	res_t        fifo_q [DEPTH];
	logic [2:0]  wr_q, rd_q;
	logic [3:0]  cnt_q;

	logic [3:0]   m;
	logic [P-1:0] beg, fin, pnext;
	logic [55:0]  cand;
	logic [3:0]   len;
	logic [15:0]  prev, c;
	logic [4:0]   fl;
	logic         done, h_emit, f_emit, expo;
	res_t         h_r, f_r, r0, r1;
	logic [1:0]   nres;
	logic         is_dig, id_st, id_pt, is_sp;
	logic         pop;

	assign s_axis_tready = cnt_q <= 4'(DEPTH - 4);
	assign pop = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = cnt_q != 4'd0;
	assign m_axis_tdata = TDW'({fifo_q[rd_q].e, fifo_q[rd_q].s});
	assign m_axis_tuser = {fifo_q[rd_q].pr, fifo_q[rd_q].k};
	assign m_axis_tlast = fifo_q[rd_q].dn;

	always_comb begin
		c = unit_s1;
		is_dig = c >= CH_ZERO && c <= CH_NINE;
		id_st = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_USCORE;
		id_pt = id_st || is_dig;
		is_sp = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		pnext = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
		m = mode_q;
		beg = beg_q;
		fin = fin_q;
		cand = cand_q;
		len = len_q;
		prev = prev_q;
		fl = flags_q;
		done = 1'b0;
		h_emit = 1'b0;
		h_r = '{s: beg_q, e: pos_q, k: K_COMMENT, pr: 1'b1, dn: 1'b0};
		expo = 1'b0;

		if (m == M_SLASH) begin
			if (c == CH_SLASH) begin
				m = M_LINE;
				done = 1'b1;
			end else if (c == CH_STAR) begin
				m = M_BLOCK;
				fl[F_STAR] = 1'b0;
				done = 1'b1;
			end else begin
				m = M_IDLE;
			end
		end
		if (m == M_DOT) begin
			if (is_dig) begin
				m = M_NUMBER;
				fl[F_ZERO] = 1'b0;
				fl[F_HEX] = 1'b0;
				prev = CH_DOT;
			end else begin
				m = M_IDLE;
			end
		end
		if (m == M_DSPACE && !done) begin
			if (c == CH_SPACE || c == CH_TAB) done = 1'b1;
			else m = M_DWORD;
		end
		if (m == M_LINE && !done) begin
			if (c == CH_CR || c == CH_LF) begin
				h_emit = 1'b1;
				h_r.k = K_COMMENT;
				m = M_IDLE;
			end else begin
				done = 1'b1;
			end
		end
		if (m == M_NUMBER && !done) begin
			if (fl[F_ZERO]) begin
				if (c == CH_LO_X || c == CH_UP_X) fl[F_HEX] = 1'b1;
				fl[F_ZERO] = 1'b0;
			end
			expo = fl[F_HEX] ? (prev == CH_LO_P || prev == CH_UP_P)
				: (prev == CH_LO_E || prev == CH_UP_E);
			if (id_pt || c == CH_DOT || c == CH_SQUOTE
				|| ((c == CH_PLUS || c == CH_MINUS) && expo)) begin
				prev = c;
				done = 1'b1;
			end else begin
				h_emit = 1'b1;
				h_r.k = K_NUMBER;
				m = M_IDLE;
				fl[F_ZERO] = 1'b0;
				fl[F_HEX] = 1'b0;
			end
		end
		if (m == M_IDENT && !done) begin
			if (id_pt) begin
				cand = ident_add(cand, len, c);
				if (len != LEN_MAX) len = len + 1'b1;
				done = 1'b1;
			end else begin
				fin = pos_q;
				if (is_kw(cand, len)) begin
					h_emit = 1'b1;
					h_r.k = K_KEYWORD;
					m = M_IDLE;
				end else begin
					m = M_WAIT;
				end
			end
		end
		if (m == M_WAIT && !done) begin
			if (is_sp) begin
				done = 1'b1;
			end else begin
				m = M_IDLE;
				if (c == CH_LPAREN) begin
					h_emit = 1'b1;
					h_r.k = K_FUNCTION;
					h_r.e = fin;
					done = 1'b1;
				end
			end
		end
		if (m == M_DWORD && !done) begin
			if (id_pt) begin
				done = 1'b1;
			end else begin
				h_emit = 1'b1;
				h_r.k = K_DIRECTIVE;
				m = M_IDLE;
			end
		end
		if (m == M_BLOCK && !done) begin
			if (fl[F_STAR] && c == CH_SLASH) begin
				h_emit = 1'b1;
				h_r.k = K_COMMENT;
				h_r.e = pnext;
				m = M_IDLE;
				fl[F_STAR] = 1'b0;
			end else begin
				fl[F_STAR] = c == CH_STAR;
			end
			done = 1'b1;
		end
		if (m == M_STRING && !done) begin
			if (fl[F_ESC]) begin
				fl[F_ESC] = 1'b0;
			end else if (c == CH_BSLASH) begin
				fl[F_ESC] = 1'b1;
			end else if (c == (fl[F_SQUOTE] ? CH_SQUOTE : CH_DQUOTE) || c == CH_CR
				|| c == CH_LF) begin
				h_emit = 1'b1;
				h_r.k = K_STRING;
				h_r.e = pnext;
				m = M_IDLE;
				fl[F_ESC] = 1'b0;
				fl[F_SQUOTE] = 1'b0;
			end
			done = 1'b1;
		end
		if (!done) begin
			m = M_IDLE;
			beg = pos_q;
			if (c == CH_SLASH) begin
				m = M_SLASH;
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				m = M_STRING;
				fl[F_ESC] = 1'b0;
				fl[F_SQUOTE] = c == CH_SQUOTE;
			end else if (is_dig) begin
				m = M_NUMBER;
				fl[F_ZERO] = c == CH_ZERO;
				fl[F_HEX] = 1'b0;
				prev = c;
			end else if (c == CH_DOT) begin
				m = M_DOT;
			end else if (id_st) begin
				m = M_IDENT;
				cand = ident_add({56{1'b1}}, 4'd0, c);
				len = 4'd1;
			end else if (c == CH_HASH) begin
				m = M_DSPACE;
			end
		end

		f_r = '{s: beg, e: pnext, k: K_COMMENT, pr: 1'b1, dn: 1'b0};
		f_emit = 1'b0;
		case (m)
			M_LINE, M_BLOCK: f_emit = 1'b1;
			M_STRING: begin
				f_emit = 1'b1;
				f_r.k = K_STRING;
			end
			M_NUMBER: begin
				f_emit = 1'b1;
				f_r.k = K_NUMBER;
			end
			M_IDENT: begin
				f_emit = is_kw(cand, len);
				f_r.k = K_KEYWORD;
			end
			M_DSPACE, M_DWORD: begin
				f_emit = 1'b1;
				f_r.k = K_DIRECTIVE;
			end
			default: f_emit = 1'b0;
		endcase
		f_emit = f_emit && last_s1;

		r1 = f_r;
		if (h_emit) r0 = h_r;
		else if (f_emit) r0 = f_r;
		else r0 = '{s: '0, e: '0, k: K_COMMENT, pr: 1'b0, dn: 1'b0};
		if (last_s1) begin
			nres = (h_emit && f_emit) ? 2'd2 : 2'd1;
			if (h_emit && f_emit) r1.dn = 1'b1;
			else r0.dn = 1'b1;
		end else begin
			nres = {1'b0, h_emit};
		end
		if (!valid_s1) nres = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= M_IDLE;
			pos_q <= '0;
			beg_q <= '0;
			fin_q <= '0;
			cand_q <= {56{1'b1}};
			len_q <= 4'd0;
			prev_q <= 16'd0;
			flags_q <= 5'd0;
			wr_q <= 3'd0;
			rd_q <= 3'd0;
			cnt_q <= 4'd0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
			if (valid_s1) begin
				if (last_s1) begin
					mode_q <= M_IDLE;
					pos_q <= '0;
					beg_q <= '0;
					fin_q <= '0;
					cand_q <= {56{1'b1}};
					len_q <= 4'd0;
					prev_q <= 16'd0;
					flags_q <= 5'd0;
				end else begin
					mode_q <= m;
					pos_q <= pnext;
					beg_q <= beg;
					fin_q <= fin;
					cand_q <= cand;
					len_q <= len;
					prev_q <= prev;
					flags_q <= fl;
				end
			end
			wr_q <= wr_q + 3'(nres);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 4'(nres) - 4'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			unit_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (nres != 2'd0) fifo_q[wr_q] <= r0;
		if (nres == 2'd2) fifo_q[wr_q + 1'b1] <= r1;
	end

endmodule

FILE: hdl/cshl_chk.sv
// Checker: port-level properties of the C lexer core, bound to the top level.
module cshl_chk #(
	parameter int POSITION_WIDTH = 24
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [((2*POSITION_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import cshl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result beat changed under stall");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast)
		else $error("empty marker without tlast");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata == '0 && m_axis_tuser[2:0] == K_COMMENT)
		else $error("empty marker carries data");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] <= K_DIRECTIVE)
		else $error("span kind out of range");

endmodule

bind c_syntax_highlight_lexer_core cshl_chk #(.POSITION_WIDTH(POSITION_WIDTH)) u_cshl_chk (.*);

FILE: tb/tb_c_syntax_highlight_lexer_core.sv
// Testbench for the streaming C lexer: random and directed source text, span scoreboard.
`timescale 1ns / 100ps

class span_scoreboard;
	localparam logic [23:0] POS_SAT = 24'hFFFFFF;
	logic [3:0]  mode;
	logic [23:0] pos, tok_begin, id_end;
	logic [55:0] cand;
	logic [3:0]  id_len;
	logic [15:0] prev_unit;
	logic [4:0]  fl;
	logic [23:0] q_start[$], q_end[$];
	logic [2:0]  q_kind[$];
	logic        q_present[$], q_done[$];
	int          n_out, errors, n_spans;
	int          kind_seen[6];

	function new();
		errors = 0;
		n_spans = 0;
		clear_state();
	endfunction

	function void clear_state();
		mode = cshl_pkg::M_IDLE;
		pos = '0; tok_begin = '0; id_end = '0;
		cand = '1; id_len = '0; prev_unit = '0; fl = '0;
	endfunction

	function logic [23:0] bump(logic [23:0] p);
		return (p == POS_SAT) ? p : p + 24'd1;
	endfunction

	function void enqueue(logic [23:0] s, logic [23:0] e, logic [2:0] k, logic pr, logic dn);
		q_start = {q_start, s}; q_end = {q_end, e}; q_kind = {q_kind, k};
		q_present = {q_present, pr}; q_done = {q_done, dn};
	endfunction

	function void push(logic [23:0] s, logic [23:0] e, logic [2:0] k);
		if (n_out >= 2) return;
		enqueue(s, e, k, 1'b1, 1'b0);
		n_out++;
	endfunction

	function bit is_digit(logic [15:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function bit is_alpha(logic [15:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	// keyword text, indexed from its first character
	function logic [7:0] kw_char(int k, int i);
		string w;
		case (k)
			0: w = "alignas"; 1: w = "alignof"; 2: w = "auto"; 3: w = "bool";
			4: w = "break"; 5: w = "case"; 6: w = "char"; 7: w = "const";
			8: w = "constexpr"; 9: w = "continue"; 10: w = "default"; 11: w = "do";
			12: w = "double"; 13: w = "else"; 14: w = "enum"; 15: w = "extern";
			16: w = "false"; 17: w = "float"; 18: w = "for"; 19: w = "goto";
			20: w = "if"; 21: w = "inline"; 22: w = "int"; 23: w = "long";
			24: w = "nullptr"; 25: w = "register"; 26: w = "restrict"; 27: w = "return";
			28: w = "short"; 29: w = "signed"; 30: w = "sizeof"; 31: w = "static";
			32: w = $sformatf("%s_%s", "static", "assert"); 33: w = "struct";
			34: w = "switch";
			35: w = $sformatf("%s_%s", "thread", "local"); 36: w = "true";
			37: w = "typedef"; 38: w = "typeof";
			39: w = $sformatf("%s_%s", "typeof", "unqual"); 40: w = "union";
			41: w = "unsigned"; 42: w = "void";
			43: w = "volatile"; 44: w = "while"; 45: w = "_Alignas"; 46: w = "_Alignof";
			47: w = "_Atomic"; 48: w = "_BitInt"; 49: w = "_Bool"; 50: w = "_Complex";
			51: w = "_Generic"; 52: w = "_Imaginary"; 53: w = "_Noreturn";
			54: w = $sformatf("_%s_%s", "Static", "assert");
			default: w = $sformatf("_%s_%s", "Thread", "local");
		endcase
		if (i < w.len()) return w[i];
		return 8'd0;
	endfunction

	function void shrink(logic [15:0] c);
		for (int k = 0; k < 56; k++)
			if (cand[k] && (id_len == 4'd15 || kw_char(k, id_len) == 8'd0 ||
			    {8'd0, kw_char(k, id_len)} != c))
				cand[k] = 1'b0;
		if (id_len != 4'd15) id_len++;
	endfunction

	function bit keyword_hit();
		if (id_len == 4'd15) return 0;
		for (int k = 0; k < 56; k++)
			if (cand[k] && kw_char(k, id_len) == 8'd0) return 1;
		return 0;
	endfunction

	function void scan(logic [15:0] c, logic [23:0] p);
		bit again, ex;
		again = 1;
		while (again) begin
			again = 0;
			case (mode)
				cshl_pkg::M_SLASH: begin
					if (c == "/") mode = cshl_pkg::M_LINE;
					else if (c == "*") begin
						mode = cshl_pkg::M_BLOCK; fl[cshl_pkg::F_STAR] = 0;
					end else begin
						mode = cshl_pkg::M_IDLE; again = 1;
					end
				end
				cshl_pkg::M_DOT: begin
					if (is_digit(c)) begin
						mode = cshl_pkg::M_NUMBER;
						fl[cshl_pkg::F_ZERO] = 0; fl[cshl_pkg::F_HEX] = 0;
						prev_unit = cshl_pkg::CH_DOT;
					end else mode = cshl_pkg::M_IDLE;
					again = 1;
				end
				cshl_pkg::M_LINE: begin
					if (c == cshl_pkg::CH_CR || c == cshl_pkg::CH_LF) begin
						push(tok_begin, p, cshl_pkg::K_COMMENT);
						mode = cshl_pkg::M_IDLE; again = 1;
					end
				end
				cshl_pkg::M_BLOCK: begin
					if (fl[cshl_pkg::F_STAR] && c == "/") begin
						push(tok_begin, bump(p), cshl_pkg::K_COMMENT);
						mode = cshl_pkg::M_IDLE; fl[cshl_pkg::F_STAR] = 0;
					end else fl[cshl_pkg::F_STAR] = (c == cshl_pkg::CH_STAR);
				end
				cshl_pkg::M_STRING: begin
					if (fl[cshl_pkg::F_ESC]) fl[cshl_pkg::F_ESC] = 0;
					else if (c == cshl_pkg::CH_BSLASH) fl[cshl_pkg::F_ESC] = 1;
					else if (c == (fl[cshl_pkg::F_SQUOTE] ? cshl_pkg::CH_SQUOTE :
					         cshl_pkg::CH_DQUOTE) || c == cshl_pkg::CH_CR ||
					         c == cshl_pkg::CH_LF) begin
						push(tok_begin, bump(p), cshl_pkg::K_STRING);
						mode = cshl_pkg::M_IDLE;
						fl[cshl_pkg::F_ESC] = 0; fl[cshl_pkg::F_SQUOTE] = 0;
					end
				end
				cshl_pkg::M_NUMBER: begin
					if (fl[cshl_pkg::F_ZERO]) begin
						if (c == "x" || c == "X") fl[cshl_pkg::F_HEX] = 1;
						fl[cshl_pkg::F_ZERO] = 0;
					end
					ex = fl[cshl_pkg::F_HEX] ? (prev_unit == "p" || prev_unit == "P")
					                         : (prev_unit == "e" || prev_unit == "E");
					if (is_alpha(c) || is_digit(c) || c == cshl_pkg::CH_DOT ||
					    c == cshl_pkg::CH_SQUOTE ||
					    ((c == cshl_pkg::CH_PLUS || c == cshl_pkg::CH_MINUS) && ex))
						prev_unit = c;
					else begin
						push(tok_begin, p, cshl_pkg::K_NUMBER);
						mode = cshl_pkg::M_IDLE;
						fl[cshl_pkg::F_ZERO] = 0; fl[cshl_pkg::F_HEX] = 0;
						again = 1;
					end
				end
				cshl_pkg::M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) shrink(c);
					else begin
						id_end = p;
						if (keyword_hit()) begin
							push(tok_begin, p, cshl_pkg::K_KEYWORD);
							mode = cshl_pkg::M_IDLE;
						end else mode = cshl_pkg::M_WAIT;
						again = 1;
					end
				end
				cshl_pkg::M_WAIT: begin
					if (!(c == cshl_pkg::CH_SPACE || (c >= 9 && c <= 13))) begin
						mode = cshl_pkg::M_IDLE;
						if (c == cshl_pkg::CH_LPAREN)
							push(tok_begin, id_end, cshl_pkg::K_FUNCTION);
						else again = 1;
					end
				end
				cshl_pkg::M_DSPACE: begin
					if (!(c == cshl_pkg::CH_SPACE || c == cshl_pkg::CH_TAB)) begin
						mode = cshl_pkg::M_DWORD; again = 1;
					end
				end
				cshl_pkg::M_DWORD: begin
					if (!(is_alpha(c) || is_digit(c))) begin
						push(tok_begin, p, cshl_pkg::K_DIRECTIVE);
						mode = cshl_pkg::M_IDLE; again = 1;
					end
				end
				default: begin
					mode = cshl_pkg::M_IDLE;
					tok_begin = p;
					if (c == cshl_pkg::CH_SLASH) mode = cshl_pkg::M_SLASH;
					else if (c == cshl_pkg::CH_DQUOTE || c == cshl_pkg::CH_SQUOTE) begin
						mode = cshl_pkg::M_STRING;
						fl[cshl_pkg::F_ESC] = 0;
						fl[cshl_pkg::F_SQUOTE] = (c == cshl_pkg::CH_SQUOTE);
					end else if (is_digit(c)) begin
						mode = cshl_pkg::M_NUMBER;
						fl[cshl_pkg::F_HEX] = 0;
						fl[cshl_pkg::F_ZERO] = (c == cshl_pkg::CH_ZERO);
						prev_unit = c;
					end else if (c == cshl_pkg::CH_DOT) mode = cshl_pkg::M_DOT;
					else if (is_alpha(c)) begin
						mode = cshl_pkg::M_IDENT;
						cand = '1; id_len = 0;
						shrink(c);
					end else if (c == cshl_pkg::CH_HASH) mode = cshl_pkg::M_DSPACE;
				end
			endcase
		end
	endfunction

	function void note_char(logic [15:0] c, logic last);
		logic [23:0] e;
		n_out = 0;
		scan(c, pos);
		e = bump(pos);
		pos = e;
		if (last) begin
			case (mode)
				cshl_pkg::M_LINE, cshl_pkg::M_BLOCK: push(tok_begin, e, cshl_pkg::K_COMMENT);
				cshl_pkg::M_STRING: push(tok_begin, e, cshl_pkg::K_STRING);
				cshl_pkg::M_NUMBER: push(tok_begin, e, cshl_pkg::K_NUMBER);
				cshl_pkg::M_IDENT: if (keyword_hit()) push(tok_begin, e, cshl_pkg::K_KEYWORD);
				cshl_pkg::M_DSPACE, cshl_pkg::M_DWORD:
					push(tok_begin, e, cshl_pkg::K_DIRECTIVE);
				default: ;
			endcase
			if (n_out == 0) enqueue('0, '0, cshl_pkg::K_COMMENT, 1'b0, 1'b1);
			else q_done[$] = 1'b1;
			clear_state();
		end
	endfunction

	function void check_span(logic [23:0] s, logic [23:0] e, logic [2:0] k, logic pr,
		logic dn);
		if (q_start.size() == 0) begin
			$error("span beat with nothing expected: start %0d end %0d kind %0d", s, e, k);
			errors++;
			return;
		end
		if (s !== q_start[0]) begin
			$error("span_start expected %0d actual %0d", q_start[0], s); errors++;
		end
		if (e !== q_end[0]) begin
			$error("span_end expected %0d actual %0d", q_end[0], e); errors++;
		end
		if (k !== q_kind[0]) begin
			$error("span_kind expected %0d actual %0d", q_kind[0], k); errors++;
		end
		if (pr !== q_present[0]) begin
			$error("span_present expected %0d actual %0d", q_present[0], pr); errors++;
		end
		if (dn !== q_done[0]) begin
			$error("source_done expected %0d actual %0d", q_done[0], dn); errors++;
		end
		if (q_present[0] && q_kind[0] < 6) begin
			kind_seen[q_kind[0]]++;
			n_spans++;
		end
		void'(q_start.pop_front()); void'(q_end.pop_front()); void'(q_kind.pop_front());
		void'(q_present.pop_front()); void'(q_done.pop_front());
	endfunction
endclass

module tb_c_syntax_highlight_lexer_core;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	span_scoreboard spans;
	int src_idle_pct, sink_stall_pct, hold_off, n_chars;
	longint cycles;

	c_syntax_highlight_lexer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// sink: random stalls, plus a counted hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				spans.check_span(m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tuser[2:0],
					m_axis_tuser[3], m_axis_tlast);
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && s_axis_tvalid && s_axis_tready)
			spans.note_char(s_axis_tdata, s_axis_tlast);

	task automatic send_char(logic [15:0] c, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_chars++;
	endtask

	task automatic send_text(string t, logic last_at_end);
		for (int i = 0; i < t.len(); i++)
			send_char({8'd0, t[i]}, last_at_end && i == t.len() - 1);
	endtask

	task automatic go_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic string pick_piece();
		string kw[12] = '{"int", "return", $sformatf("%s_%s", "typeof", "unqual"),
			$sformatf("_%s_%s", "Static", "assert"), "while",
			$sformatf("%s_%s", "static", "assert"), $sformatf("_%s_%s", "Thread", "local"),
			"sizeof", "do", "if", "void", "unsigned"};
		string misc[20] = '{"foo(", "bar  (", "baz\t(", "x1 ", "0x1p+3 ", "1e-5;", "0x1e+2 ",
			".5 ", "3.14f ", "'a'", "\"s\\\"q\"", "'\\''", "// c\n", "/* a*b **/",
			"# define X ", "#include", "a.b ", "x/y ", "1'000 ", "\"unterminated\n"};
		case ($urandom_range(3))
			0: return {kw[$urandom_range(11)], ($urandom_range(1) ? " " : "(")};
			default: return misc[$urandom_range(19)];
		endcase
	endfunction

	task automatic random_char();
		logic [15:0] c;
		string pool;
		pool = "_(#/*.\"'\\ \n\r\teEpPxX+-0129azAZ";
		case ($urandom_range(5))
			0: c = 16'($urandom);
			1: c = 16'($urandom_range(127));
			default: c = {8'd0, pool[$urandom_range(pool.len() - 1)]};
		endcase
		send_char(c, $urandom_range(60) == 0);
	endtask

	initial begin
		spans = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off = 0;
		n_chars = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("int main(void) { return 0x1F; }", 1'b0);
		send_text(" // note\n/* b ** */ \"a\\\"b\" 'c' 1.5e+3 .7 #  define", 1'b1);
		send_text($sformatf("%s_%s _%s_%s abcdefghijklmnopq f (", "typeof", "unqual",
			"Static", "assert"), 1'b1);
		send_char(16'hFFFF, 1'b0);
		send_char(16'h0000, 1'b0);
		send_char(16'h8000, 1'b1);
		send_text("x", 1'b1);
		send_text("\"open", 1'b1);
		send_text("/", 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 25 : 57) : 0;
			sink_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 25 : 0;
			if (ph == 0) hold_off = 200;
			while (n_chars < 300 + ph * 150) begin
				if ($urandom_range(4) != 0) send_text(pick_piece(), 1'b0);
				else random_char();
			end
			send_char(16'h000A, 1'b1);
		end
		go_idle();

		while (spans.q_start.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d characters; checked %0d spans", n_chars, spans.n_spans);
		$display("kinds: comment %0d string %0d number %0d keyword %0d function %0d dir %0d",
			spans.kind_seen[0], spans.kind_seen[1], spans.kind_seen[2], spans.kind_seen[3],
			spans.kind_seen[4], spans.kind_seen[5]);
		if (spans.errors == 0 && spans.q_start.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

FILE: c_syntax_highlight_lexer_core.f
hdl/cshl_pkg.sv
hdl/c_syntax_highlight_lexer_core.sv
hdl/cshl_chk.sv
tb/tb_c_syntax_highlight_lexer_core.sv
